/* sv/dmpr_pkg.sv */
// shared types, codes and helpers for the dual motor power ramp
`timescale 1ns / 1ps

package dmpr_pkg;

   // field widths
   localparam int unsigned OP_W       = 3;
   localparam int unsigned SEL_W      = 2;
   localparam int unsigned POWER_W    = 8;
   localparam int unsigned RATE_REQ_W = 8;
   localparam int unsigned RATE_W     = 7;
   localparam int unsigned NOW_W      = 32;
   localparam int unsigned INTERVAL_W = 10;

   // reset values and limits
   localparam int unsigned TIME_BITS_DEFAULT = 32;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd20;
   localparam logic [RATE_W-1:0] RATE_RESET = 7'd10;
   localparam logic [RATE_W-1:0] RATE_MIN   = 7'd1;
   localparam logic [RATE_W-1:0] RATE_MAX   = 7'd100;
   localparam logic signed [POWER_W-1:0] POWER_MIN = -8'sd100;
   localparam logic signed [POWER_W-1:0] POWER_MAX = 8'sd100;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_UPDATE     = 3'd0,
      OP_SET_NOW    = 3'd1,
      OP_SET_SMOOTH = 3'd2,
      OP_SET_ACCEL  = 3'd3,
      OP_SET_DECEL  = 3'd4
   } op_type;

   // motor select codes
   typedef enum logic [SEL_W-1:0] {
      SEL_ONE     = 2'd0,
      SEL_TWO     = 2'd1,
      SEL_BOTH    = 2'd2,
      SEL_NEITHER = 2'd3
   } sel_type;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic [SEL_W-1:0]          motor_select;
      logic signed [POWER_W-1:0] power_request;
      logic [RATE_REQ_W-1:0]     accel_request;
      logic [RATE_REQ_W-1:0]     decel_request;
      logic [NOW_W-1:0]          now_ms;
   } req_type;

   typedef struct packed {
      logic signed [POWER_W-1:0] motor_one_level;
      logic signed [POWER_W-1:0] motor_two_level;
      logic signed [POWER_W-1:0] motor_one_goal;
      logic signed [POWER_W-1:0] motor_two_goal;
      logic                      motor_one_written;
      logic                      motor_two_written;
      logic                      still_ramping;
   } rsp_type;

   // power request limited to -100..100
   function automatic logic signed [POWER_W-1:0] clamp_power(
      input logic signed [POWER_W-1:0] raw
   );
      logic signed [POWER_W-1:0] v;
      v = raw;
      if (raw < POWER_MIN) begin
         v = POWER_MIN;
      end else if (raw > POWER_MAX) begin
         v = POWER_MAX;
      end
      return v;
   endfunction

   // rate request limited to 1..100
   function automatic logic [RATE_W-1:0] clamp_rate(
      input logic [RATE_REQ_W-1:0] raw
   );
      logic [RATE_W-1:0] v;
      v = RATE_W'(raw);
      if (raw == '0) begin
         v = RATE_MIN;
      end else if (raw > RATE_REQ_W'(RATE_MAX)) begin
         v = RATE_MAX;
      end
      return v;
   endfunction

endpackage

/* sv/dmpr_ramp.sv */
// one ramp step of a motor level toward its goal
`timescale 1ns / 1ps

module dmpr_ramp (
   input  logic signed [dmpr_pkg::POWER_W-1:0] level,
   input  logic signed [dmpr_pkg::POWER_W-1:0] goal,
   input  logic [dmpr_pkg::RATE_W-1:0]         accel_rate,
   input  logic [dmpr_pkg::RATE_W-1:0]         decel_rate,
   output logic signed [dmpr_pkg::POWER_W-1:0] stepped
);

   // one guard bit so level +/- rate never wraps
   localparam int unsigned WIDE_W = dmpr_pkg::POWER_W + 1;

   logic signed [WIDE_W-1:0] level_w;
   logic signed [WIDE_W-1:0] goal_w;
   logic signed [WIDE_W-1:0] level_mag;
   logic signed [WIDE_W-1:0] goal_mag;
   logic signed [WIDE_W-1:0] rate_w;
   logic signed [WIDE_W-1:0] moved;
   logic signed [WIDE_W-1:0] limited;

   assign level_w   = {level[dmpr_pkg::POWER_W-1], level};
   assign goal_w    = {goal[dmpr_pkg::POWER_W-1], goal};
   assign level_mag = (level_w < 0) ? -level_w : level_w;
   assign goal_mag  = (goal_w < 0) ? -goal_w : goal_w;

   // speeding up uses the acceleration rate, anything else decelerates
   assign rate_w = (goal_mag > level_mag) ? {2'b00, accel_rate} : {2'b00, decel_rate};

   always_comb begin
      if (level_w < goal_w) begin
         moved   = level_w + rate_w;
         limited = (moved > goal_w) ? goal_w : moved;
      end else begin
         moved   = level_w - rate_w;
         limited = (moved < goal_w) ? goal_w : moved;
      end
   end

   assign stepped = dmpr_pkg::POWER_W'(limited);

endmodule

/* sv/dual_motor_power_ramp.sv */
// top level of the dual motor power ramp
// Two-channel motor power ramp with separate acceleration and deceleration
// slew rates. Each request transfer produces exactly one response transfer
// carrying both motor levels, both goals, the per-motor written flags and a
// ramping flag. Requests are registered on acceptance, processed by one pass
// of combinational logic against the motor state and the result lands in a
// response register, so one transfer per cycle is sustained while rsp_ready
// is high. A request is taken whenever the request register is empty or hands
// its item to the response register in the same cycle, so req_ready depends
// combinationally on rsp_ready and a stalled response holds at most one
// request behind it. Update requests (operation 0) step every unsettled motor
// once the elapsed time, now_ms minus the last step time modulo 2^TIME_BITS,
// reaches the step interval register. The interval is written over the csr
// port, which is always ready and must only be written while no request is
// in flight. There is no clearing pass after reset; state is in flip-flops.
`timescale 1ns / 1ps

module dual_motor_power_ramp #(
   parameter int unsigned TIME_BITS = dmpr_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dmpr_pkg::req_type                   req_payload,

   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dmpr_pkg::rsp_type                   rsp_payload,

   // step interval register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dmpr_pkg::INTERVAL_W-1:0]     csr_data
);

   // elapsed time compared at the wider of time and interval widths
   localparam int unsigned CMP_W =
      (TIME_BITS > dmpr_pkg::INTERVAL_W) ? TIME_BITS : dmpr_pkg::INTERVAL_W;

   // ---------------------------------------------------------------------
   // handshake and stage registers
   // ---------------------------------------------------------------------
   logic                req_vld_ff, req_vld_in;
   dmpr_pkg::req_type   req_ff, req_in;
   logic                rsp_vld_ff, rsp_vld_in;
   dmpr_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_free;
   logic                advance;
   logic                req_take;

   // motor state
   logic signed [dmpr_pkg::POWER_W-1:0] level_one_ff, level_one_in;
   logic signed [dmpr_pkg::POWER_W-1:0] level_two_ff, level_two_in;
   logic signed [dmpr_pkg::POWER_W-1:0] goal_one_ff, goal_one_in;
   logic signed [dmpr_pkg::POWER_W-1:0] goal_two_ff, goal_two_in;
   logic [dmpr_pkg::RATE_W-1:0]         accel_ff, accel_in;
   logic [dmpr_pkg::RATE_W-1:0]         decel_ff, decel_in;
   logic [TIME_BITS-1:0]                last_step_ff, last_step_in;
   logic [dmpr_pkg::INTERVAL_W-1:0]     interval_ff, interval_in;

   // processing signals
   logic signed [dmpr_pkg::POWER_W-1:0] power_lim;
   logic signed [dmpr_pkg::POWER_W-1:0] step_one;
   logic signed [dmpr_pkg::POWER_W-1:0] step_two;
   logic [dmpr_pkg::RATE_W-1:0]         accel_lim;
   logic [dmpr_pkg::RATE_W-1:0]         decel_lim;
   logic [TIME_BITS-1:0]                now_t;
   logic [TIME_BITS-1:0]                elapsed;
   logic [CMP_W-1:0]                    elapsed_w;
   logic                                interval_due;
   logic                                pick_one;
   logic                                pick_two;
   logic                                wrote_one;
   logic                                wrote_two;
   logic                                step_taken;
   logic                                unsettled_one;
   logic                                unsettled_two;

   // ---------------------------------------------------------------------
   // flow control: the response register frees when empty or drained,
   // the request register moves on whenever the response register frees
   // ---------------------------------------------------------------------
   assign rsp_free  = !rsp_vld_ff || rsp_ready;
   assign advance   = req_vld_ff && rsp_free;
   assign req_ready = !req_vld_ff || rsp_free;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      req_vld_in = req_vld_ff;
      req_in     = req_ff;
      if (req_take) begin
         req_vld_in = 1'b1;
         req_in     = req_payload;
      end else if (advance) begin
         req_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // request decode
   // ---------------------------------------------------------------------
   assign power_lim = dmpr_pkg::clamp_power(req_ff.power_request);
   assign accel_lim = dmpr_pkg::clamp_rate(req_ff.accel_request);
   assign decel_lim = dmpr_pkg::clamp_rate(req_ff.decel_request);

   assign pick_one = req_ff.motor_select inside {dmpr_pkg::SEL_ONE, dmpr_pkg::SEL_BOTH};
   assign pick_two = req_ff.motor_select inside {dmpr_pkg::SEL_TWO, dmpr_pkg::SEL_BOTH};

   // wrapping time difference, only the low TIME_BITS of now_ms count
   assign now_t        = TIME_BITS'(req_ff.now_ms);
   assign elapsed      = now_t - last_step_ff;
   assign elapsed_w    = CMP_W'(elapsed);
   assign interval_due = elapsed_w >= CMP_W'(interval_ff);

   assign unsettled_one = level_one_ff != goal_one_ff;
   assign unsettled_two = level_two_ff != goal_two_ff;

   // one slew step per motor
   dmpr_ramp u_ramp_one (
      .level      (level_one_ff),
      .goal       (goal_one_ff),
      .accel_rate (accel_ff),
      .decel_rate (decel_ff),
      .stepped    (step_one)
   );

   dmpr_ramp u_ramp_two (
      .level      (level_two_ff),
      .goal       (goal_two_ff),
      .accel_rate (accel_ff),
      .decel_rate (decel_ff),
      .stepped    (step_two)
   );

   // ---------------------------------------------------------------------
   // state update for the request in the request register
   // ---------------------------------------------------------------------
   always_comb begin
      level_one_in = level_one_ff;
      level_two_in = level_two_ff;
      goal_one_in  = goal_one_ff;
      goal_two_in  = goal_two_ff;
      accel_in     = accel_ff;
      decel_in     = decel_ff;
      last_step_in = last_step_ff;
      wrote_one    = 1'b0;
      wrote_two    = 1'b0;
      step_taken   = 1'b0;

      if (advance) begin
         case (req_ff.operation)
            dmpr_pkg::OP_UPDATE: begin
               if (interval_due) begin
                  // a due tick restarts the interval even with nothing to move
                  step_taken   = 1'b1;
                  last_step_in = now_t;
                  if (unsettled_one) begin
                     level_one_in = step_one;
                     wrote_one    = 1'b1;
                  end
                  if (unsettled_two) begin
                     level_two_in = step_two;
                     wrote_two    = 1'b1;
                  end
               end
            end
            dmpr_pkg::OP_SET_NOW: begin
               if (pick_one) begin
                  level_one_in = power_lim;
                  goal_one_in  = power_lim;
                  wrote_one    = 1'b1;
               end
               if (pick_two) begin
                  level_two_in = power_lim;
                  goal_two_in  = power_lim;
                  wrote_two    = 1'b1;
               end
            end
            dmpr_pkg::OP_SET_SMOOTH: begin
               if (pick_one) begin
                  goal_one_in = power_lim;
               end
               if (pick_two) begin
                  goal_two_in = power_lim;
               end
               // zero requests keep the old rate, zero decel follows new accel
               if (req_ff.accel_request != '0) begin
                  accel_in = accel_lim;
               end
               if (req_ff.decel_request != '0) begin
                  decel_in = decel_lim;
               end else if (req_ff.accel_request != '0) begin
                  decel_in = accel_lim;
               end
            end
            dmpr_pkg::OP_SET_ACCEL: begin
               accel_in = accel_lim;
            end
            dmpr_pkg::OP_SET_DECEL: begin
               decel_in = decel_lim;
            end
            default: begin
               // unused codes only report the state
            end
         endcase
      end
   end

   // interval register write
   always_comb begin
      interval_in = interval_ff;
      if (csr_valid && csr_ready) begin
         interval_in = csr_data;
      end
   end

   // ---------------------------------------------------------------------
   // response build: on a due tick the ramping flag reports the motors
   // unsettled before the step, otherwise the state after the request
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_in = rsp_ff;
      if (advance) begin
         rsp_in.motor_one_level   = level_one_in;
         rsp_in.motor_two_level   = level_two_in;
         rsp_in.motor_one_goal    = goal_one_in;
         rsp_in.motor_two_goal    = goal_two_in;
         rsp_in.motor_one_written = wrote_one;
         rsp_in.motor_two_written = wrote_two;
         rsp_in.still_ramping     = step_taken ? (wrote_one || wrote_two) :
                                    ((level_one_in != goal_one_in) ||
                                     (level_two_in != goal_two_in));
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff   <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         level_one_ff <= '0;
         level_two_ff <= '0;
         goal_one_ff  <= '0;
         goal_two_ff  <= '0;
         accel_ff     <= dmpr_pkg::RATE_RESET;
         decel_ff     <= dmpr_pkg::RATE_RESET;
         last_step_ff <= '0;
         interval_ff  <= dmpr_pkg::INTERVAL_RESET;
      end else begin
         req_vld_ff   <= req_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
         level_one_ff <= level_one_in;
         level_two_ff <= level_two_in;
         goal_one_ff  <= goal_one_in;
         goal_two_ff  <= goal_two_in;
         accel_ff     <= accel_in;
         decel_ff     <= decel_in;
         last_step_ff <= last_step_in;
         interval_ff  <= interval_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   // a processed request always shows up as a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("processed request did not reach the response register");

   // a settled response means both levels sit on their goals
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ff.still_ramping) |->
         ((rsp_ff.motor_one_level == rsp_ff.motor_one_goal) &&
          (rsp_ff.motor_two_level == rsp_ff.motor_two_goal)))
      else $error("ramping flag clear while a motor is off its goal");

   // levels never leave the power range
   assert property (@(posedge clock) disable iff (reset)
      (level_one_ff >= dmpr_pkg::POWER_MIN) && (level_one_ff <= dmpr_pkg::POWER_MAX) &&
      (level_two_ff >= dmpr_pkg::POWER_MIN) && (level_two_ff <= dmpr_pkg::POWER_MAX))
      else $error("motor level out of range");

   // rates stay within 1..100
   assert property (@(posedge clock) disable iff (reset)
      (accel_ff >= dmpr_pkg::RATE_MIN) && (accel_ff <= dmpr_pkg::RATE_MAX) &&
      (decel_ff >= dmpr_pkg::RATE_MIN) && (decel_ff <= dmpr_pkg::RATE_MAX))
      else $error("ramp rate out of range");
`endif

endmodule

/* bench/testbench.sv */
// self-checking bench for the dual motor power ramp: predictor, scoreboard, drivers
`timescale 1ns / 1ps

module testbench;
   import dmpr_pkg::*;

   // operation codes the block must ignore
   localparam logic [OP_W-1:0] OP_UNKNOWN_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_UNKNOWN_LAST  = 3'd7;

   // stimulus size
   localparam int unsigned PHASE_COUNT      = 8;
   localparam int unsigned ITEMS_PER_PHASE  = 250;
   localparam int unsigned SETTLE_CYCLES    = 6;

   // ---------------------------------------------------------------
   // motor ramp predictor and response scoreboard
   // ---------------------------------------------------------------
   class motor_ramp_scoreboard;
      logic signed [POWER_W-1:0] level_one, level_two, goal_one, goal_two;
      logic [RATE_W-1:0]         accel_rate, decel_rate;
      logic [NOW_W-1:0]          last_step_ms;
      logic [INTERVAL_W-1:0]     step_interval;
      rsp_type                   pending_reports[$];
      int unsigned               error_count;

      function new();
         level_one     = '0;
         level_two     = '0;
         goal_one      = '0;
         goal_two      = '0;
         accel_rate    = RATE_RESET;
         decel_rate    = RATE_RESET;
         last_step_ms  = '0;
         step_interval = INTERVAL_RESET;
         error_count   = 0;
      endfunction

      function void set_interval(logic [INTERVAL_W-1:0] value);
         step_interval = value;
      endfunction

      function int unsigned pending_count();
         return pending_reports.size();
      endfunction

      // power request limited to the drive range
      function logic signed [POWER_W-1:0] limit_power(logic signed [POWER_W-1:0] raw);
         if (raw < POWER_MIN) begin
            return POWER_MIN;
         end
         if (raw > POWER_MAX) begin
            return POWER_MAX;
         end
         return raw;
      endfunction

      // rate request limited to 1..100
      function logic [RATE_W-1:0] limit_rate(logic [RATE_REQ_W-1:0] raw);
         if (raw == '0) begin
            return RATE_MIN;
         end
         if (raw > RATE_REQ_W'(RATE_MAX)) begin
            return RATE_MAX;
         end
         return raw[RATE_W-1:0];
      endfunction

      // one slew step of one motor, done in int so nothing wraps
      function logic signed [POWER_W-1:0] ramp_toward(logic signed [POWER_W-1:0] lvl,
                                                      logic signed [POWER_W-1:0] tgt);
         int cur, aim, rate, cur_mag, aim_mag;
         cur = int'(lvl);
         aim = int'(tgt);
         cur_mag = (cur < 0) ? -cur : cur;
         aim_mag = (aim < 0) ? -aim : aim;
         if (aim_mag > cur_mag) begin
            rate = int'(accel_rate);
         end else begin
            rate = int'(decel_rate);
         end
         if (cur < aim) begin
            cur = cur + rate;
            if (cur > aim) cur = aim;
         end else begin
            cur = cur - rate;
            if (cur < aim) cur = aim;
         end
         return cur[POWER_W-1:0];
      endfunction

      // apply one accepted request and queue the response it must produce
      function void note_request(req_type item);
         rsp_type                   report;
         logic                      pick_one, pick_two, wrote_one, wrote_two;
         logic                      stepped, ramping;
         logic [NOW_W-1:0]          elapsed;
         logic signed [POWER_W-1:0] power;
         pick_one  = (item.motor_select == SEL_ONE) || (item.motor_select == SEL_BOTH);
         pick_two  = (item.motor_select == SEL_TWO) || (item.motor_select == SEL_BOTH);
         wrote_one = 1'b0;
         wrote_two = 1'b0;
         stepped   = 1'b0;
         ramping   = 1'b0;
         power     = limit_power(item.power_request);
         case (item.operation)
            OP_UPDATE: begin
               elapsed = item.now_ms - last_step_ms;
               if (elapsed >= NOW_W'(step_interval)) begin
                  last_step_ms = item.now_ms;
                  if (level_one != goal_one) begin
                     level_one = ramp_toward(level_one, goal_one);
                     wrote_one = 1'b1;
                  end
                  if (level_two != goal_two) begin
                     level_two = ramp_toward(level_two, goal_two);
                     wrote_two = 1'b1;
                  end
                  stepped = 1'b1;
                  ramping = wrote_one || wrote_two;
               end
            end
            OP_SET_NOW: begin
               if (pick_one) begin
                  level_one = power;
                  goal_one  = power;
                  wrote_one = 1'b1;
               end
               if (pick_two) begin
                  level_two = power;
                  goal_two  = power;
                  wrote_two = 1'b1;
               end
            end
            OP_SET_SMOOTH: begin
               if (pick_one) goal_one = power;
               if (pick_two) goal_two = power;
               if (item.accel_request != '0) accel_rate = limit_rate(item.accel_request);
               if (item.decel_request != '0) begin
                  decel_rate = limit_rate(item.decel_request);
               end else if (item.accel_request != '0) begin
                  decel_rate = accel_rate;
               end
            end
            OP_SET_ACCEL: accel_rate = limit_rate(item.accel_request);
            OP_SET_DECEL: decel_rate = limit_rate(item.decel_request);
            default: ;
         endcase
         if (!stepped) begin
            ramping = (level_one != goal_one) || (level_two != goal_two);
         end
         report.motor_one_level   = level_one;
         report.motor_two_level   = level_two;
         report.motor_one_goal    = goal_one;
         report.motor_two_goal    = goal_two;
         report.motor_one_written = wrote_one;
         report.motor_two_written = wrote_two;
         report.still_ramping     = ramping;
         pending_reports.push_back(report);
      endfunction

      function void compare_field(string field, logic signed [7:0] want,
                                  logic signed [7:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
            error_count++;
         end
      endfunction

      // compare one accepted response with the oldest prediction
      function void check_report(rsp_type seen);
         rsp_type want;
         if (pending_reports.size() == 0) begin
            $display("%0t: response with none outstanding, expected nothing, actual %h",
                     $time, seen);
            error_count++;
            return;
         end
         want = pending_reports.pop_front();
         compare_field("motor_one_level", want.motor_one_level, seen.motor_one_level);
         compare_field("motor_two_level", want.motor_two_level, seen.motor_two_level);
         compare_field("motor_one_goal", want.motor_one_goal, seen.motor_one_goal);
         compare_field("motor_two_goal", want.motor_two_goal, seen.motor_two_goal);
         compare_field("motor_one_written", 8'(want.motor_one_written),
                       8'(seen.motor_one_written));
         compare_field("motor_two_written", 8'(want.motor_two_written),
                       8'(seen.motor_two_written));
         compare_field("still_ramping", 8'(want.still_ramping), 8'(seen.still_ramping));
      endfunction
   endclass

   // ---------------------------------------------------------------
   // block hookup
   // ---------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [INTERVAL_W-1:0] csr_data;

   dual_motor_power_ramp dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   motor_ramp_scoreboard ramp_sb = new();

   // stimulus-side state
   logic [NOW_W-1:0] sim_ms;        // millisecond clock fed to update transfers
   int unsigned      cur_interval;  // mirror of the interval register for time stepping
   logic             no_idle;       // set during stretches with no gaps on either side

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------
   // helpers
   // ---------------------------------------------------------------

   // gap length: mostly none or short, a few long
   function automatic int unsigned idle_length();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // advance the millisecond clock; mostly just past the interval so motors step,
   // sometimes short of it, sometimes a jump anywhere including across the wrap
   function automatic logic [NOW_W-1:0] next_time();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         sim_ms = sim_ms + cur_interval + $urandom_range(0, 2);
      end else if (r < 85) begin
         sim_ms = sim_ms + $urandom_range(0, cur_interval);
      end else if (r < 93) begin
         sim_ms = sim_ms + $urandom_range(0, 5);
      end else if (r < 97) begin
         sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      end else begin
         sim_ms = $urandom;
      end
      return sim_ms;
   endfunction

   function automatic req_type make_req(logic [OP_W-1:0] op, sel_type sel,
                                        logic signed [POWER_W-1:0] power,
                                        logic [RATE_REQ_W-1:0] accel,
                                        logic [RATE_REQ_W-1:0] decel,
                                        logic [NOW_W-1:0] now);
      req_type item;
      item.operation     = op;
      item.motor_select  = sel;
      item.power_request = power;
      item.accel_request = accel;
      item.decel_request = decel;
      item.now_ms        = now;
      return item;
   endfunction

   // rate request: many zeros and small rates so ramps take several steps
   function automatic logic [RATE_REQ_W-1:0] random_rate();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 25) return '0;
      if (r < 65) return RATE_REQ_W'($urandom_range(1, 20));
      return RATE_REQ_W'($urandom_range(0, 255));
   endfunction

   function automatic req_type random_request();
      req_type     item;
      int unsigned r;
      int          power;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         item.operation = OP_UPDATE;
      end else if (r < 65) begin
         item.operation = OP_SET_SMOOTH;
      end else if (r < 75) begin
         item.operation = OP_SET_NOW;
      end else if (r < 85) begin
         item.operation = OP_SET_ACCEL;
      end else if (r < 95) begin
         item.operation = OP_SET_DECEL;
      end else begin
         item.operation = OP_W'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
      end
      item.motor_select = SEL_W'($urandom_range(SEL_ONE, SEL_NEITHER));
      // full byte half the time so the clamp is hit, else inside the drive range
      if ($urandom_range(0, 1) == 0) begin
         item.power_request = POWER_W'($urandom_range(0, 255));
      end else begin
         power = int'($urandom_range(0, 200)) - 100;
         item.power_request = power[POWER_W-1:0];
      end
      item.accel_request = random_rate();
      item.decel_request = random_rate();
      if (item.operation == OP_UPDATE) begin
         item.now_ms = next_time();
      end else begin
         item.now_ms = $urandom;
      end
      return item;
   endfunction

   // ---------------------------------------------------------------
   // drivers: change at the falling edge, sample at the rising edge
   // ---------------------------------------------------------------

   // one request transfer, then a random gap; valid stays high across back-to-back items
   task automatic push_request(req_type item);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      ramp_sb.note_request(item);
      @(negedge clock);
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // drop valid and let every outstanding response come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (ramp_sb.pending_count() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // interval register write, only while the block is idle
   task automatic write_interval(logic [INTERVAL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      ramp_sb.set_interval(value);
      cur_interval = 32'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // response side: ready in runs with random stalls between them
   initial begin
      int unsigned run, gap;
      rsp_ready = 1'b0;
      forever begin
         run = $urandom_range(1, 16);
         repeat (run) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end
         gap = idle_length();
         repeat (gap) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
      end
   end

   // every response transfer goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         ramp_sb.check_report(rsp_payload);
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      req_type               item;
      int unsigned           phase, done_items, steps;
      logic [INTERVAL_W-1:0] setting;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      sim_ms       = '0;
      cur_interval = 32'(INTERVAL_RESET);
      no_idle      = 1'b0;

      // synchronous reset, released at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, interval at its reset value of 20
      // update at time zero: nothing elapsed, no step
      push_request(make_req(OP_UPDATE, SEL_BOTH, 8'sd0, 8'd0, 8'd0, 32'd0));
      // set-now with power beyond both clamp limits
      push_request(make_req(OP_SET_NOW, SEL_BOTH, 8'sd127, 8'd0, 8'd0, 32'd0));
      push_request(make_req(OP_SET_NOW, SEL_ONE, -8'sd128, 8'd0, 8'd0, 32'd0));
      push_request(make_req(OP_SET_NOW, SEL_TWO, 8'sd101, 8'd0, 8'd0, 32'd0));
      push_request(make_req(OP_SET_NOW, SEL_NEITHER, -8'sd101, 8'd0, 8'd0, 32'd0));
      // smooth set on neither motor with both rates zero keeps the rates
      push_request(make_req(OP_SET_SMOOTH, SEL_NEITHER, 8'sd50, 8'd0, 8'd0, 32'd0));
      // zero decel copies a clamped accel
      push_request(make_req(OP_SET_SMOOTH, SEL_BOTH, 8'sd0, 8'd200, 8'd0, 32'd0));
      // motor one crosses zero: decel toward zero, then accel away from it
      push_request(make_req(OP_SET_SMOOTH, SEL_ONE, 8'sd100, 8'd7, 8'd255, 32'd0));
      // zero accel keeps the old one, decel alone changes
      push_request(make_req(OP_SET_SMOOTH, SEL_TWO, -8'sd100, 8'd0, 8'd3, 32'd0));
      // rate items at both clamp limits
      push_request(make_req(OP_SET_ACCEL, SEL_NEITHER, 8'sd0, 8'd0, 8'd0, 32'd0));
      push_request(make_req(OP_SET_ACCEL, SEL_ONE, 8'sd0, 8'd255, 8'd0, 32'd0));
      push_request(make_req(OP_SET_DECEL, SEL_TWO, 8'sd0, 8'd0, 8'd0, 32'd0));
      push_request(make_req(OP_SET_DECEL, SEL_BOTH, 8'sd0, 8'd0, 8'd101, 32'd0));
      push_request(make_req(OP_SET_ACCEL, SEL_BOTH, 8'sd0, 8'd9, 8'd0, 32'd0));
      push_request(make_req(OP_SET_DECEL, SEL_ONE, 8'sd0, 8'd0, 8'd30, 32'd0));
      // one short of the interval, exactly on it, then short again
      push_request(make_req(OP_UPDATE, SEL_BOTH, 8'sd0, 8'd0, 8'd0, 32'd19));
      push_request(make_req(OP_UPDATE, SEL_BOTH, 8'sd0, 8'd0, 8'd0, 32'd20));
      push_request(make_req(OP_UPDATE, SEL_BOTH, 8'sd0, 8'd0, 8'd0, 32'd39));
      // top of the time range, then elapsed across the wrap
      push_request(make_req(OP_UPDATE, SEL_BOTH, 8'sd0, 8'd0, 8'd0, 32'hFFFF_FFFF));
      push_request(make_req(OP_UPDATE, SEL_BOTH, 8'sd0, 8'd0, 8'd0, 32'd18));
      push_request(make_req(OP_UPDATE, SEL_BOTH, 8'sd0, 8'd0, 8'd0, 32'd19));
      // unused operation codes change nothing
      push_request(make_req(OP_UNKNOWN_FIRST, SEL_BOTH, 8'sd77, 8'd5, 8'd5, 32'd500));
      push_request(make_req(OP_UNKNOWN_LAST, SEL_ONE, -8'sd77, 8'd5, 8'd5, 32'd500));
      push_request(make_req(OP_UPDATE, SEL_BOTH, 8'sd0, 8'd0, 8'd0, 32'd100));
      push_request(make_req(OP_UPDATE, SEL_BOTH, 8'sd0, 8'd0, 8'd0, 32'd120));
      sim_ms = 32'd120;

      // random part: one interval setting per phase, extremes included
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         case (phase)
            0: setting = '0;
            1: setting = 10'd1;
            2: setting = 10'd1000;
            3: setting = 10'd1023;
            4: setting = 10'd20;
            5: setting = INTERVAL_W'($urandom_range(2, 60));
            6: setting = INTERVAL_W'($urandom_range(0, 1023));
            default: setting = 10'd5;
         endcase
         write_interval(setting);
         // two stretches with no gaps on either side
         no_idle = (phase == 4) || (phase == 7);
         done_items = 0;
         while (done_items < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 60) begin
               // new goal then a run of updates that mostly let the motors step
               item = random_request();
               item.operation = OP_SET_SMOOTH;
               push_request(item);
               steps = $urandom_range(2, 25);
               repeat (steps) begin
                  item = random_request();
                  item.operation = OP_UPDATE;
                  item.now_ms = next_time();
                  push_request(item);
               end
               done_items += steps + 1;
            end else begin
               item = random_request();
               push_request(item);
               if (item.operation <= OP_SET_DECEL) done_items++;
            end
         end
      end
      no_idle = 1'b0;

      // drain and report
      wait_idle();
      if (ramp_sb.error_count == 0 && ramp_sb.pending_count() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* files.f */
sv/dmpr_pkg.sv
sv/dmpr_ramp.sv
sv/dual_motor_power_ramp.sv
bench/testbench.sv
